@@ design/bmp24_pkg.sv @@
// ============================================================================
// bmp24_pkg
// Types, constants and helpers shared by the BMP to ARGB framebuffer writer.
// ============================================================================
`default_nettype none

package bmp24_pkg;

    localparam int HEADER_BYTES = 54;
    localparam int MAX_DIM      = 4096;
    localparam int DIM_W        = 13;
    localparam int HDR_IDX_W    = 6;

    localparam int IDX_TYPE   = 0;
    localparam int IDX_WIDTH  = 18;
    localparam int IDX_HEIGHT = 22;
    localparam int IDX_BPP    = 28;

    localparam logic [15:0] BMP_TYPE = 16'h4d42;
    localparam logic [15:0] BMP_BPP  = 16'd24;
    localparam logic [7:0]  ALPHA    = 8'hff;

    localparam logic [DIM_W-1:0] PANEL_WIDTH_RESET  = 13'd1080;
    localparam logic [DIM_W-1:0] PANEL_HEIGHT_RESET = 13'd1920;

    localparam logic [1:0] CFG_PANEL_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_PANEL_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_FRAME_BASE   = 2'd2;

    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_REJECT = 1'b1;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_PIXEL  = 2'd1,
        PH_PAD    = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    typedef struct packed {
        logic [DIM_W-1:0] panel_width;
        logic [DIM_W-1:0] panel_height;
        logic [31:0]      frame_base;
    } cfg_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] pixel_word;
        logic [31:0] write_address;
    } result_t;

    // Panel sizes above the largest supported dimension are clamped.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] value);
        logic [DIM_W-1:0] lim;
        lim = DIM_W'(MAX_DIM);
        return (value > lim) ? lim : value;
    endfunction

endpackage

`default_nettype wire

@@ design/bmp24_parse.sv @@
// ============================================================================
// bmp24_parse
// Header parser and pixel address generator: one file byte per step.
// ============================================================================
`default_nettype none

module bmp24_parse
    import bmp24_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] data_byte,
    input  wire logic       first_byte,
    input  wire cfg_t       cfg,
    output logic            res_valid,
    output result_t         res
);

    logic [HDR_IDX_W-1:0] header_index_reg, header_index_next;
    phase_t               phase_reg, phase_next;
    logic [15:0]          file_type_reg, file_type_next;
    logic [15:0]          bpp_reg, bpp_next;
    logic [31:0]          width_reg, width_next;
    logic [31:0]          height_reg, height_next;
    logic [DIM_W-1:0]     column_reg, column_next;
    logic [DIM_W-1:0]     rows_reg, rows_next;
    logic [1:0]           bip_reg, bip_next;
    logic [1:0]           pad_reg, pad_next;
    logic [15:0]          partial_reg, partial_next;
    logic [31:0]          row_addr_reg, row_addr_next;

    logic [HDR_IDX_W-1:0] cur_index;
    phase_t               cur_phase;
    logic [15:0]          cur_type;
    logic [15:0]          cur_bpp;
    logic [31:0]          cur_width;
    logic [31:0]          cur_height;
    logic [DIM_W-1:0]     cur_column;
    logic [DIM_W-1:0]     cur_rows;
    logic [1:0]           cur_bip;
    logic [1:0]           cur_pad;
    logic [15:0]          cur_partial;
    logic [31:0]          cur_row_addr;

    logic [DIM_W-1:0]     pw;
    logic [DIM_W-1:0]     ph;
    logic [DIM_W-1:0]     w13;
    logic [DIM_W-1:0]     h13;
    logic [DIM_W-1:0]     sx;
    logic [DIM_W-1:0]     sy;
    logic [DIM_W-1:0]     top_row;
    logic [25:0]          top_offset;
    logic                 header_ok;
    logic [HDR_IDX_W-1:0] field_off;
    logic [DIM_W-1:0]     column_inc;
    logic [DIM_W-1:0]     rows_dec;

    assign pw = eff_dim(cfg.panel_width);
    assign ph = eff_dim(cfg.panel_height);

    always_comb
    begin
        // A first-byte mark clears the parse state before the byte is used.
        if (first_byte)
        begin
            cur_index    = '0;
            cur_phase    = PH_HEADER;
            cur_type     = '0;
            cur_bpp      = '0;
            cur_width    = '0;
            cur_height   = '0;
            cur_column   = '0;
            cur_rows     = '0;
            cur_bip      = '0;
            cur_pad      = '0;
            cur_partial  = '0;
            cur_row_addr = '0;
        end
        else
        begin
            cur_index    = header_index_reg;
            cur_phase    = phase_reg;
            cur_type     = file_type_reg;
            cur_bpp      = bpp_reg;
            cur_width    = width_reg;
            cur_height   = height_reg;
            cur_column   = column_reg;
            cur_rows     = rows_reg;
            cur_bip      = bip_reg;
            cur_pad      = pad_reg;
            cur_partial  = partial_reg;
            cur_row_addr = row_addr_reg;
        end
    end

    assign w13        = cur_width[DIM_W-1:0];
    assign h13        = cur_height[DIM_W-1:0];
    assign header_ok  = (cur_type == BMP_TYPE) && (cur_bpp == BMP_BPP)
                        && !cur_width[31] && (cur_width <= 32'(pw))
                        && !cur_height[31] && (cur_height <= 32'(ph));
    assign sx         = DIM_W'((pw - w13) >> 1);
    assign sy         = DIM_W'((ph - h13) >> 1);
    assign top_row    = sy + h13 - DIM_W'(1);
    assign top_offset = 26'(top_row * pw) + 26'(sx);
    assign column_inc = cur_column + DIM_W'(1);
    assign rows_dec   = cur_rows - DIM_W'(1);

    always_comb
    begin
        header_index_next = cur_index;
        phase_next        = cur_phase;
        file_type_next    = cur_type;
        bpp_next          = cur_bpp;
        width_next        = cur_width;
        height_next       = cur_height;
        column_next       = cur_column;
        rows_next         = cur_rows;
        bip_next          = cur_bip;
        pad_next          = cur_pad;
        partial_next      = cur_partial;
        row_addr_next     = cur_row_addr;
        res_valid         = 1'b0;
        res.kind          = KIND_PIXEL;
        res.write_address = '0;
        res.pixel_word    = '0;
        field_off         = '0;

        unique case (cur_phase)
            PH_HEADER:
            begin
                header_index_next = cur_index + HDR_IDX_W'(1);
                case (cur_index) inside
                    [HDR_IDX_W'(IDX_TYPE) : HDR_IDX_W'(IDX_TYPE + 1)]:
                    begin
                        field_off      = cur_index - HDR_IDX_W'(IDX_TYPE);
                        file_type_next = cur_type
                                         | (16'(data_byte) << {field_off[0], 3'b000});
                    end
                    [HDR_IDX_W'(IDX_WIDTH) : HDR_IDX_W'(IDX_WIDTH + 3)]:
                    begin
                        field_off  = cur_index - HDR_IDX_W'(IDX_WIDTH);
                        width_next = cur_width
                                     | (32'(data_byte) << {field_off[1:0], 3'b000});
                    end
                    [HDR_IDX_W'(IDX_HEIGHT) : HDR_IDX_W'(IDX_HEIGHT + 3)]:
                    begin
                        field_off   = cur_index - HDR_IDX_W'(IDX_HEIGHT);
                        height_next = cur_height
                                      | (32'(data_byte) << {field_off[1:0], 3'b000});
                    end
                    [HDR_IDX_W'(IDX_BPP) : HDR_IDX_W'(IDX_BPP + 1)]:
                    begin
                        field_off = cur_index - HDR_IDX_W'(IDX_BPP);
                        bpp_next  = cur_bpp
                                    | (16'(data_byte) << {field_off[0], 3'b000});
                    end
                    default:
                    begin
                    end
                endcase

                if (cur_index == HDR_IDX_W'(HEADER_BYTES - 1))
                begin
                    if (!header_ok)
                    begin
                        phase_next = PH_DONE;
                        res_valid  = 1'b1;
                        res.kind   = KIND_REJECT;
                    end
                    else if (w13 == '0 || h13 == '0)
                    begin
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        row_addr_next = cfg.frame_base + {4'b0000, top_offset, 2'b00};
                        column_next   = '0;
                        rows_next     = h13;
                        bip_next      = '0;
                        partial_next  = '0;
                        pad_next      = '0;
                        phase_next    = PH_PIXEL;
                    end
                end
            end

            PH_PIXEL:
            begin
                unique case (cur_bip)
                    2'd0:
                    begin
                        partial_next = {8'h00, data_byte};
                        bip_next     = 2'd1;
                    end
                    2'd1:
                    begin
                        partial_next = {data_byte, cur_partial[7:0]};
                        bip_next     = 2'd2;
                    end
                    default:
                    begin
                        res_valid         = 1'b1;
                        res.kind          = KIND_PIXEL;
                        res.pixel_word    = {ALPHA, data_byte, cur_partial};
                        res.write_address = cur_row_addr
                                            + {{(30 - DIM_W){1'b0}}, cur_column, 2'b00};
                        bip_next          = 2'd0;
                        column_next       = column_inc;
                        if (column_inc >= w13)
                        begin
                            column_next   = '0;
                            rows_next     = rows_dec;
                            row_addr_next = cur_row_addr
                                            - {{(30 - DIM_W){1'b0}}, pw, 2'b00};
                            if (rows_dec == '0)
                            begin
                                phase_next = PH_DONE;
                            end
                            else if (w13[1:0] != 2'd0)
                            begin
                                pad_next   = w13[1:0];
                                phase_next = PH_PAD;
                            end
                        end
                    end
                endcase
            end

            PH_PAD:
            begin
                pad_next = cur_pad - 2'd1;
                if (pad_next == 2'd0)
                begin
                    phase_next = PH_PIXEL;
                end
            end

            PH_DONE:
            begin
            end

            default:
            begin
            end
        endcase

        if (!step)
        begin
            res_valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_index_reg <= '0;
            phase_reg        <= PH_HEADER;
            file_type_reg    <= '0;
            bpp_reg          <= '0;
            width_reg        <= '0;
            height_reg       <= '0;
            column_reg       <= '0;
            rows_reg         <= '0;
            bip_reg          <= '0;
            pad_reg          <= '0;
            partial_reg      <= '0;
            row_addr_reg     <= '0;
        end
        else if (step)
        begin
            header_index_reg <= header_index_next;
            phase_reg        <= phase_next;
            file_type_reg    <= file_type_next;
            bpp_reg          <= bpp_next;
            width_reg        <= width_next;
            height_reg       <= height_next;
            column_reg       <= column_next;
            rows_reg         <= rows_next;
            bip_reg          <= bip_next;
            pad_reg          <= pad_next;
            partial_reg      <= partial_next;
            row_addr_reg     <= row_addr_next;
        end
    end

endmodule

`default_nettype wire

@@ design/bmp24_skid.sv @@
// ============================================================================
// bmp24_skid
// Output register with one skid entry, so the input side can hand over one
// further result while a result waits.
// ============================================================================
`default_nettype none

module bmp24_skid
    import bmp24_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    output logic         can_push,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_data
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_reg, out_next;
    result_t skid_reg, skid_next;

    assign can_push  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = push_data;
                out_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_next       = push_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

endmodule

`default_nettype wire

@@ design/bmp24_to_argb_framebuffer_writer.sv @@
// ============================================================================
// bmp24_to_argb_framebuffer_writer
// Writes a 24-bit bottom-up BMP file into an ARGB8888 framebuffer.
// ============================================================================
// The file arrives one byte per item on the s_axis channel; s_axis_tuser marks
// the first byte of a file and restarts header parsing. After the 54-byte
// header the image is checked against the panel size and, if accepted, is
// centred on the panel. Every third pixel byte yields one item on the m_axis
// channel carrying the framebuffer byte address and the opaque ARGB word; a
// rejected header yields a single item with tuser set and zero data. Row
// padding and bytes after the image produce nothing.
// A byte is taken in every cycle while s_axis_tready is high. Its result is
// registered and leaves on m_axis from the output register. When the receiver
// stalls, one further result is held in a skid entry, and s_axis_tready then
// drops until the output register drains.
// Reset clears the parser to the start of a header, empties the output
// stages and loads the panel size 1080 by 1920 with a framebuffer base of
// zero. The registers are written through cfg_we, cfg_index and cfg_data.
// ============================================================================
`default_nettype none

module bmp24_to_argb_framebuffer_writer
    import bmp24_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // data_byte [7:0]
    input  wire logic        s_axis_tuser,  // first_byte [0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,  // write_address [31:0], pixel_word [63:32]
    output logic             m_axis_tuser,  // kind [0]
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    cfg_t    cfg_reg;
    logic    accept;
    logic    res_valid;
    result_t res;
    result_t out_data;
    logic    can_push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.panel_width  <= PANEL_WIDTH_RESET;
            cfg_reg.panel_height <= PANEL_HEIGHT_RESET;
            cfg_reg.frame_base   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PANEL_WIDTH:  cfg_reg.panel_width  <= cfg_data[DIM_W-1:0];
                CFG_PANEL_HEIGHT: cfg_reg.panel_height <= cfg_data[DIM_W-1:0];
                CFG_FRAME_BASE:   cfg_reg.frame_base   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign s_axis_tready = can_push;
    assign accept        = s_axis_tvalid && can_push;

    bmp24_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (accept),
        .data_byte  (s_axis_tdata),
        .first_byte (s_axis_tuser),
        .cfg        (cfg_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    bmp24_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .can_push  (can_push),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_data)
    );

    assign m_axis_tdata = {out_data.pixel_word, out_data.write_address};
    assign m_axis_tuser = out_data.kind;

endmodule

`default_nettype wire

@@ design/bmp24_checker.sv @@
// ============================================================================
// bmp24_checker
// Port-level checks for the BMP to ARGB framebuffer writer.
// ============================================================================
`default_nettype none

module bmp24_checker
    import bmp24_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [63:0] m_axis_tdata,
    input wire logic        m_axis_tuser
);

    // A pending result is not withdrawn while the receiver stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("Result item withdrawn while stalled.");

    // The input side only stops when a result is waiting at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("Input stalled with an empty output register.");

    // A rejection carries neither an address nor a pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_REJECT) |-> m_axis_tdata == '0)
        else $error("Rejection item carries non-zero data.");

    // Every pixel written is opaque.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_PIXEL) |-> m_axis_tdata[63:56] == ALPHA)
        else $error("Pixel item is not opaque.");

endmodule

bind bmp24_to_argb_framebuffer_writer bmp24_checker u_bmp24_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

@@ bench/bmp24_to_argb_framebuffer_writer_tb.sv @@
// ============================================================================
// bmp24_to_argb_framebuffer_writer_tb
// Streams BMP files byte by byte into the framebuffer writer and checks every
// pixel write and header rejection against a cycle-free model of the parser.
// A table of hand-picked files covers the header checks, empty images,
// restarts, clamped and zero panel sizes, address wrap and a panel change in
// the middle of an image. Random files with random panels and random stalls
// on both streams follow.
// ============================================================================

module bmp24_to_argb_framebuffer_writer_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bmp24_pkg::*;

    localparam int QUIET_LIMIT = 5000;
    localparam int PLAN_ROWS   = 23;

    typedef enum logic [1:0] {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;
    typedef enum logic [1:0] {CHK_PREDICTED, CHK_REJECT, CHK_SILENT} check_t;

    typedef struct packed {
        logic [12:0] pw;
        logic [12:0] ph;
        logic [31:0] base;
        logic [15:0] ftype;
        logic [15:0] bpp;
        logic [31:0] w;
        logic [31:0] h;
        logic        mark;
        int          cut;
        int          trail;
        fill_t       fill;
        int          hold;
        check_t      chk;
    } file_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // data_byte [7:0]
    logic        s_axis_tuser = 1'b0;    // first_byte [0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;           // write_address [31:0], pixel_word [63:32]
    logic        m_axis_tuser;           // kind [0]
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_PANEL_WIDTH;
    logic [31:0] cfg_data = 32'h0;

    bmp24_to_argb_framebuffer_writer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    logic [12:0] panel_w = PANEL_WIDTH_RESET;
    logic [12:0] panel_h = PANEL_HEIGHT_RESET;
    logic [31:0] fb_base = 32'h0;

    logic [5:0]  hdr_idx;
    phase_t      phase;
    logic [15:0] ftype_acc;
    logic [15:0] bpp_acc;
    logic [31:0] img_w;
    logic [31:0] img_h;
    logic [12:0] col;
    logic [12:0] rows_left;
    logic [1:0]  byte_in_px;
    logic [1:0]  pad_left;
    logic [15:0] px_partial;
    logic [31:0] row_addr;

    result_t     pending_writes[$];
    file_row_t   plan [PLAN_ROWS];
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;
    int unsigned body_bytes = 0;
    bit          calm = 1'b0;

    initial forever #4 clk = ~clk;

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic logic [12:0] clamp_dim(input logic [12:0] v);
        return (v[12] && (v[11:0] != 12'd0)) ? 13'h1000 : v;
    endfunction

    function automatic logic [7:0] fill_byte(input fill_t f);
        case (f)
            FILL_ZERO: return 8'h00;
            FILL_ONES: return 8'hff;
            default:   return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [12:0] pick_dim();
        int unsigned k;
        k = $urandom_range(99);
        if (k < 70)
            return 13'($urandom_range(1, 12));
        if (k < 78)
            return 13'd0;
        if (k < 86)
            return $urandom_range(1) ? 13'd4096 : 13'h1fff;
        return 13'($urandom_range(8191));
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 50)
                $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
        end
    endfunction

    task automatic clear_parser();
        hdr_idx    = '0;
        phase      = PH_HEADER;
        ftype_acc  = '0;
        bpp_acc    = '0;
        img_w      = '0;
        img_h      = '0;
        col        = '0;
        rows_left  = '0;
        byte_in_px = '0;
        pad_left   = '0;
        px_partial = '0;
        row_addr   = '0;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic first, output bit made,
                              output result_t res);
        int          idx;
        logic [31:0] pw_e;
        logic [31:0] ph_e;
        logic [31:0] sx;
        logic [31:0] sy;
        made = 1'b0;
        res  = '0;
        if (first)
            clear_parser();
        case (phase)
            PH_HEADER:
            begin
                idx = int'(hdr_idx);
                if (idx < IDX_TYPE + 2)
                    ftype_acc[8*(idx-IDX_TYPE) +: 8] = b;
                else if (idx >= IDX_WIDTH && idx < IDX_WIDTH + 4)
                    img_w[8*(idx-IDX_WIDTH) +: 8] = b;
                else if (idx >= IDX_HEIGHT && idx < IDX_HEIGHT + 4)
                    img_h[8*(idx-IDX_HEIGHT) +: 8] = b;
                else if (idx >= IDX_BPP && idx < IDX_BPP + 2)
                    bpp_acc[8*(idx-IDX_BPP) +: 8] = b;
                hdr_idx = hdr_idx + 6'd1;
                if (idx + 1 >= HEADER_BYTES)
                begin
                    pw_e = 32'(clamp_dim(panel_w));
                    ph_e = 32'(clamp_dim(panel_h));
                    if (!(ftype_acc == BMP_TYPE && bpp_acc == BMP_BPP
                          && !img_w[31] && img_w <= pw_e && !img_h[31] && img_h <= ph_e))
                    begin
                        phase    = PH_DONE;
                        made     = 1'b1;
                        res.kind = KIND_REJECT;
                    end
                    else if (img_w == 0 || img_h == 0)
                        phase = PH_DONE;
                    else
                    begin
                        sx         = (pw_e - img_w) >> 1;
                        sy         = (ph_e - img_h) >> 1;
                        row_addr   = fb_base + 32'd4 * ((sy + img_h - 32'd1) * pw_e + sx);
                        col        = '0;
                        rows_left  = img_h[12:0];
                        byte_in_px = '0;
                        px_partial = '0;
                        pad_left   = '0;
                        phase      = PH_PIXEL;
                    end
                end
            end
            PH_PIXEL:
            begin
                if (byte_in_px == 2'd0)
                begin
                    px_partial = {8'h00, b};
                    byte_in_px = 2'd1;
                end
                else if (byte_in_px == 2'd1)
                begin
                    px_partial[15:8] = b;
                    byte_in_px       = 2'd2;
                end
                else
                begin
                    made              = 1'b1;
                    res.kind          = KIND_PIXEL;
                    res.pixel_word    = {ALPHA, b, px_partial};
                    res.write_address = row_addr + 32'd4 * 32'(col);
                    byte_in_px        = 2'd0;
                    col               = col + 13'd1;
                    if (32'(col) >= img_w)
                    begin
                        col       = '0;
                        rows_left = rows_left - 13'd1;
                        row_addr  = row_addr - 32'd4 * 32'(clamp_dim(panel_w));
                        if (rows_left == 13'd0)
                            phase = PH_DONE;
                        else if (img_w[1:0] != 2'd0)
                        begin
                            pad_left = img_w[1:0];
                            phase    = PH_PAD;
                        end
                    end
                end
            end
            PH_PAD:
            begin
                pad_left = pad_left - 2'd1;
                if (pad_left == 2'd0)
                    phase = PH_PIXEL;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic feed_byte(input logic [7:0] b, input logic first, input bit typed);
        bit      made;
        result_t res;
        while (!calm && $urandom_range(99) < 29)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= first;
        do
            @(posedge clk);
        while (!s_axis_tready);
        parse_byte(b, first, made, res);
        if (made && !typed)
            pending_writes.push_back(res);
    endtask

    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_panel(input logic [12:0] pw, input logic [12:0] ph,
                              input logic [31:0] base);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PANEL_WIDTH;
        cfg_data  <= {19'($urandom), pw};
        @(posedge clk);
        cfg_index <= CFG_PANEL_HEIGHT;
        cfg_data  <= {19'($urandom), ph};
        @(posedge clk);
        cfg_index <= CFG_FRAME_BASE;
        cfg_data  <= base;
        @(posedge clk);
        cfg_we  <= 1'b0;
        panel_w = pw;
        panel_h = ph;
        fb_base = base;
    endtask

    // A hold point drains the block, widens the panel by four columns and loads a
    // random framebuffer base in the middle of the image.
    task automatic send_file(input file_row_t row);
        int         npix;
        int         total;
        logic [7:0] b;
        if (row.w > 32'(clamp_dim(panel_w)) || row.h > 32'(clamp_dim(panel_h)))
            npix = 0;
        else
            npix = int'(row.h) * (int'(row.w) * 3 + int'(row.w % 4));
        total = (row.cut != 0) ? row.cut : HEADER_BYTES + npix + row.trail;
        if (row.chk == CHK_REJECT)
            pending_writes.push_back({KIND_REJECT, 32'h0, 32'h0});
        for (int i = 0; i < total; i++)
        begin
            if (row.hold != 0 && i == row.hold)
            begin
                settle_block();
                load_panel(panel_w + 13'd4, panel_h, $urandom);
            end
            if (i < IDX_TYPE + 2)
                b = 8'(row.ftype >> (8 * (i - IDX_TYPE)));
            else if (i >= IDX_WIDTH && i < IDX_WIDTH + 4)
                b = 8'(row.w >> (8 * (i - IDX_WIDTH)));
            else if (i >= IDX_HEIGHT && i < IDX_HEIGHT + 4)
                b = 8'(row.h >> (8 * (i - IDX_HEIGHT)));
            else if (i >= IDX_BPP && i < IDX_BPP + 2)
                b = 8'(row.bpp >> (8 * (i - IDX_BPP)));
            else if (i < HEADER_BYTES)
                b = 8'($urandom_range(255));
            else
                b = fill_byte(row.fill);
            feed_byte(b, row.mark && i == 0, row.chk != CHK_PREDICTED);
            if (i < HEADER_BYTES + npix)
                body_bytes++;
        end
    endtask

    function automatic file_row_t random_file();
        file_row_t   r;
        int unsigned pw_e;
        int unsigned ph_e;
        int unsigned k;
        int unsigned n;
        pw_e    = clamp_dim(panel_w);
        ph_e    = clamp_dim(panel_h);
        r       = '0;
        r.ftype = BMP_TYPE;
        r.bpp   = BMP_BPP;
        r.mark  = ($urandom_range(99) >= 3);
        r.w     = (pw_e == 0 || $urandom_range(9) == 0) ? 0
                  : $urandom_range(1, (pw_e < 6) ? pw_e : 6);
        r.h     = (ph_e == 0 || $urandom_range(9) == 0) ? 0
                  : $urandom_range(1, (ph_e < 4) ? ph_e : 4);
        r.trail = $urandom_range(4);
        k       = $urandom_range(99);
        r.fill  = (k < 5) ? FILL_ZERO : (k < 10) ? FILL_ONES : FILL_RANDOM;
        r.chk   = CHK_PREDICTED;
        k       = $urandom_range(99);
        if (k < 16)
        begin
            case ($urandom_range(5))
                0:
                begin
                    n          = $urandom_range(15);
                    r.ftype[n] = ~r.ftype[n];
                end
                1:
                begin
                    r.bpp = 16'($urandom_range(65535));
                    if (r.bpp == BMP_BPP)
                        r.bpp = 16'd32;
                end
                2: r.w = $urandom | 32'h8000_0000;
                3: r.h = $urandom | 32'h8000_0000;
                4: r.w = pw_e + 1 + $urandom_range(40);
                default: r.h = ph_e + 1 + $urandom_range(40);
            endcase
        end
        else if (k < 28)
            r.cut = $urandom_range(1, HEADER_BYTES + int'(r.h * (r.w * 3 + r.w % 4)));
        return r;
    endfunction

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        result_t want;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_writes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 50)
                        $display("%0t: unexpected item, expected none, actual kind %0b data %h",
                                 $time, m_axis_tuser, m_axis_tdata);
                end
                else
                begin
                    want = pending_writes.pop_front();
                    check_field("kind", 32'(want.kind), 32'(m_axis_tuser));
                    check_field("write_address", want.write_address, m_axis_tdata[31:0]);
                    check_field("pixel_word", want.pixel_word, m_axis_tdata[63:32]);
                end
            end
            m_axis_tready <= calm || ($urandom_range(99) >= 29);
        end
    end

    initial
    begin
        int unsigned start;
        int unsigned nfiles;
        plan = '{
            '{1080, 1920, 32'h0, 16'h4d42, 24, 2, 2, 0, 0, 3, FILL_RANDOM, 0, CHK_PREDICTED},
            '{16, 16, 32'h1000, 16'h4d43, 24, 2, 2, 1, 0, 2, FILL_RANDOM, 0, CHK_REJECT},
            '{16, 16, 32'h1000, 16'h4d42, 32, 2, 2, 1, 0, 2, FILL_RANDOM, 0, CHK_REJECT},
            '{16, 16, 32'h1000, 16'h4d42, 24, 32'hffff_ffff, 2, 1, 0, 2, FILL_RANDOM, 0,
              CHK_REJECT},
            '{16, 16, 32'h1000, 16'h4d42, 24, 2, 32'h8000_0000, 1, 0, 2, FILL_RANDOM, 0,
              CHK_REJECT},
            '{16, 16, 32'h1000, 16'h4d42, 24, 17, 1, 1, 0, 0, FILL_RANDOM, 0, CHK_REJECT},
            '{16, 16, 32'h1000, 16'h4d42, 24, 1, 17, 1, 0, 0, FILL_RANDOM, 0, CHK_REJECT},
            '{16, 16, 32'h1000, 16'h4d42, 24, 16, 1, 1, 0, 1, FILL_ONES, 0, CHK_PREDICTED},
            '{16, 16, 32'h1000, 16'h4d42, 24, 1, 16, 1, 0, 1, FILL_ZERO, 0, CHK_PREDICTED},
            '{16, 16, 32'h1000, 16'h4d42, 24, 0, 5, 1, 0, 6, FILL_RANDOM, 0, CHK_SILENT},
            '{16, 16, 32'h1000, 16'h4d42, 24, 3, 0, 1, 0, 6, FILL_RANDOM, 0, CHK_SILENT},
            '{16, 16, 32'h1000, 16'h4d42, 24, 1, 1, 1, 20, 0, FILL_RANDOM, 0, CHK_SILENT},
            '{16, 16, 32'h1000, 16'h4d42, 24, 3, 3, 1, 59, 0, FILL_RANDOM, 0, CHK_PREDICTED},
            '{0, 0, 32'h0, 16'h4d42, 24, 0, 0, 1, 0, 2, FILL_RANDOM, 0, CHK_SILENT},
            '{0, 0, 32'h0, 16'h4d42, 24, 1, 1, 1, 0, 2, FILL_RANDOM, 0, CHK_REJECT},
            '{8191, 8191, 32'h4000_0000, 16'h4d42, 24, 4096, 4096, 1, 63, 0, FILL_RANDOM, 0,
              CHK_PREDICTED},
            '{8191, 8191, 32'h4000_0000, 16'h4d42, 24, 4097, 1, 1, 0, 0, FILL_RANDOM, 0,
              CHK_REJECT},
            '{4096, 1, 32'hffff_fff0, 16'h4d42, 24, 1, 1, 1, 0, 1, FILL_ONES, 0,
              CHK_PREDICTED},
            '{5, 4, 32'h8000_0000, 16'h4d42, 24, 5, 4, 1, 0, 4, FILL_RANDOM, 0, CHK_PREDICTED},
            '{5, 4, 32'h8000_0000, 16'h4d42, 24, 2, 2, 1, 0, 0, FILL_RANDOM, 0, CHK_PREDICTED},
            '{5, 4, 32'h8000_0000, 16'h4d42, 24, 3, 2, 1, 0, 0, FILL_RANDOM, 0, CHK_PREDICTED},
            '{6, 6, 32'h2000_0000, 16'h4d42, 24, 2, 3, 1, 0, 2, FILL_RANDOM, 65,
              CHK_PREDICTED},
            '{1, 1, 32'hffff_fffc, 16'h4d42, 24, 1, 1, 1, 0, 0, FILL_ZERO, 0, CHK_PREDICTED}
        };
        clear_parser();
        while (!rst_n)
            @(posedge clk);

        for (int n = 0; n < PLAN_ROWS; n++)
        begin
            if (n != 0)
            begin
                settle_block();
                load_panel(plan[n].pw, plan[n].ph, plan[n].base);
            end
            send_file(plan[n]);
        end

        start  = body_bytes;
        nfiles = 0;
        while (body_bytes - start < 380)
        begin
            calm = (body_bytes - start >= 80) && (body_bytes - start < 280);
            if (nfiles % 6 == 0)
            begin
                settle_block();
                load_panel(pick_dim(), pick_dim(), $urandom);
            end
            if ($urandom_range(99) < 4)
                repeat ($urandom_range(1, 20)) feed_byte(8'($urandom_range(255)), 1'b0, 1'b0);
            else
                send_file(random_file());
            nfiles++;
        end
        calm = 1'b0;

        settle_block();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ sim.f @@
design/bmp24_pkg.sv
design/bmp24_parse.sv
design/bmp24_skid.sv
design/bmp24_to_argb_framebuffer_writer.sv
design/bmp24_checker.sv
bench/bmp24_to_argb_framebuffer_writer_tb.sv
